/* rtl/tcl_pkg.sv */
// Shared types and constants of the tone curve linearizer.
// No dependencies; tcl_pow, the top level and the testbench files use it by scoped names.
`default_nettype none

package tcl_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int LEN_W           = 13;
    localparam int POW_W           = 49;

    localparam logic [POW_W-1:0] POW_ONE = POW_W'(65536);
    localparam logic [POW_W-1:0] POW_CAP = POW_W'(1) << 48;

    // curve_mode codes
    localparam logic [2:0] MODE_IDENT = 3'd0;
    localparam logic [2:0] MODE_TABLE = 3'd1;
    localparam logic [2:0] MODE_GAMMA = 3'd2;
    localparam logic [2:0] MODE_P1    = 3'd3;
    localparam logic [2:0] MODE_P2    = 3'd4;
    localparam logic [2:0] MODE_P3    = 3'd5;
    localparam logic [2:0] MODE_P4    = 3'd6;
    localparam logic [2:0] MODE_SPARE = 3'd7;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE = 3'd0;
    localparam logic [2:0] CFG_G    = 3'd1;
    localparam logic [2:0] CFG_A    = 3'd2;
    localparam logic [2:0] CFG_B    = 3'd3;
    localparam logic [2:0] CFG_C    = 3'd4;
    localparam logic [2:0] CFG_D    = 3'd5;
    localparam logic [2:0] CFG_E    = 3'd6;
    localparam logic [2:0] CFG_F    = 3'd7;

    // per-item data that rides alongside the power pipeline
    typedef struct packed {
        logic                kind;
        logic                neg;
        logic [32:0]         m;
        logic [LEN_W-1:0]    len;
        logic [11:0]         widx;
        logic [15:0]         wval;
        logic signed [49:0]  cm;
        logic                mge;
    } t_side;

endpackage

`default_nettype wire

/* rtl/tcl_ram.sv */
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module tcl_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

/* rtl/tcl_pow.sv */
// Pipelined fixed-point power unit: normalize, log2 by squaring, scale by g,
// exp2 by restoring square roots, final shift and cap. Uses tcl_pkg.
`default_nettype none

module tcl_pow (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [49:0]   i_base,
    input  wire logic signed [31:0]   i_g,
    input  wire tcl_pkg::t_side       i_side,
    output logic                      o_valid,
    output logic [tcl_pkg::POW_W-1:0] o_pow,
    output tcl_pkg::t_side            o_side
);

    localparam int NORM0 = 1;
    localparam int LOG0  = NORM0 + 6;
    localparam int MUL0  = LOG0 + tcl_pkg::FRAC_BITS;
    localparam int EXP0  = MUL0 + 2;
    localparam int FIN   = EXP0 + tcl_pkg::FRAC_BITS * 32;

    typedef struct packed {
        tcl_pkg::t_side             side;
        logic                       bneg;
        logic                       bzero;
        logic [63:0]                x;
        logic [5:0]                 lz;
        logic [31:0]                y;
        logic [15:0]                frac;
        logic signed [55:0]         prod;
        logic signed [39:0]         e;
        logic [63:0]                n;
        logic [63:0]                res;
        logic [tcl_pkg::POW_W-1:0]  pw;
    } t_pw;

    t_pw  r_st  [FIN+1];
    t_pw  n_st  [FIN+1];
    logic r_vld [FIN+1];

    function automatic t_pw step(input int s, input t_pw p, input logic signed [31:0] g);
        t_pw                q;
        int                 sh;
        int                 qi;
        int                 j;
        int                 k;
        logic [31:0]        yin;
        logic [63:0]        sq;
        logic [63:0]        zsrc;
        logic [63:0]        n0;
        logic [63:0]        r0;
        logic [63:0]        bitv;
        logic [63:0]        tr;
        logic [63:0]        zl;
        logic [7:0]         pm;
        logic signed [23:0] logv;
        logic signed [23:0] ip;
        logic [5:0]         rs;
        logic [4:0]         ls;
        q = p;
        if (s < LOG0) begin
            // leading-zero search, one shift distance a stage
            sh = 32 >> (s - NORM0);
            if ((p.x >> (64 - sh)) == 64'd0) begin
                q.x  = p.x << sh;
                q.lz = p.lz + 6'(sh);
            end
        end else if (s < MUL0) begin
            yin = (s == LOG0) ? {1'b0, p.x[63:33]} : p.y;
            sq  = 64'(yin) * 64'(yin);
            q.y = sq[61] ? {1'b0, sq[61:31]} : sq[61:30];
            q.frac = {p.frac[14:0], sq[61]};
        end else if (s == MUL0) begin
            pm     = 8'd31 - 8'(p.lz);
            logv   = $signed({pm, p.frac});
            q.prod = 56'(logv) * 56'(g);
        end else if (s == MUL0 + 1) begin
            q.e = 40'((p.prod + 56'sd32768) >>> 16);
        end else if (s < FIN) begin
            qi   = s - EXP0;
            j    = qi >> 5;
            k    = qi & 31;
            zsrc = (j == 0) ? (64'd1 << 30) : p.res;
            if (k == 0) begin
                n0 = (p.e[j] ? (zsrc << 1) : zsrc) << 30;
                r0 = 64'd0;
            end else begin
                n0 = p.n;
                r0 = p.res;
            end
            bitv = 64'd1 << (62 - 2 * k);
            tr   = r0 + bitv;
            if (n0 >= tr) begin
                q.n   = n0 - tr;
                q.res = (r0 >> 1) + bitv;
            end else begin
                q.n   = n0;
                q.res = r0 >> 1;
            end
        end else begin
            ip = p.e[39:16];
            rs = 6'(24'sd14 - ip);
            ls = 5'(ip - 24'sd14);
            zl = p.res << ls;
            priority if (p.bneg) begin
                q.pw = '0;
            end else if (p.bzero) begin
                q.pw = (g > 32'sd0) ? '0 : ((g == 32'sd0) ? tcl_pkg::POW_ONE : tcl_pkg::POW_CAP);
            end else if (ip > 24'sd31) begin
                q.pw = tcl_pkg::POW_CAP;
            end else if (ip <= -24'sd48) begin
                q.pw = '0;
            end else if (ip < 24'sd14) begin
                q.pw = tcl_pkg::POW_W'((p.res + (64'd1 << (rs - 6'd1))) >> rs);
            end else begin
                q.pw = (zl > 64'(tcl_pkg::POW_CAP)) ? tcl_pkg::POW_CAP
                                                    : tcl_pkg::POW_W'(zl);
            end
        end
        return q;
    endfunction

    always_comb begin
        n_st[0]       = '0;
        n_st[0].side  = i_side;
        n_st[0].bneg  = i_base[49];
        n_st[0].bzero = (i_base == 50'sd0);
        n_st[0].x     = {i_base[47:0], 16'd0};
        for (int s = 1; s <= FIN; s++) begin
            n_st[s] = step(s, r_st[s-1], i_g);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s <= FIN; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= FIN; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= FIN; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_valid = r_vld[FIN];
    assign o_pow   = r_st[FIN].pw;
    assign o_side  = r_st[FIN].side;

endmodule

`default_nettype wire

/* rtl/tone_curve_linearizer.sv */
// Top level of the tone curve linearizer: front stages, power pipeline,
// table interpolation and output register. Uses tcl_pkg, tcl_pow, tcl_ram.
`default_nettype none

// Usage
//   Input channel (i_valid / o_ready): one item per transfer. kind 0 converts
//   i_sample (s15.16) through the curve chosen by curve_mode; kind 1 writes
//   i_entry_value into table entry i_entry_index and sets the table length
//   to that index plus one. A write gives no result.
//   Output channel (o_valid / i_ready): one result per convert item, in
//   order: o_linear_value (s15.16) and o_saturated when the value clipped.
//   Configuration: i_cfg_we writes register i_cfg_index from i_cfg_data at
//   once; write only while no item is in flight.
//   Throughput: one item per cycle while the pipeline is not held. Every
//   item walks the same fixed chain of registers: three front stages, the
//   power pipeline (one input stage, six normalize stages, 16 log2
//   squaring stages, two scale stages, 16 x 32 square-root steps for exp2,
//   one final shift stage), three table stages and the output register.
//   The exp2 root steps make up most of that chain.
//   Stall: while the output register holds an untaken result and the last
//   stage holds another one, the whole pipeline holds; otherwise items keep
//   flowing and bubbles are squeezed out at the output.
//   Reset (synchronous, active low) clears all valid bits, the table length
//   and the configuration registers to their defaults. Table contents are not cleared.
module tone_curve_linearizer #(
    parameter int TABLE_DEPTH = tcl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic signed [31:0] i_sample,
    input  wire logic [11:0]        i_entry_index,
    input  wire logic [15:0]        i_entry_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_linear_value,
    output logic                    o_saturated,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = tcl_pkg::LEN_W;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] v;
        logic [LW-1:0]      len;
        logic [11:0]        widx;
        logic [15:0]        wval;
    } t_s1;

    typedef struct packed {
        tcl_pkg::t_side     side;
        logic [29:0]        pos;
        logic signed [51:0] par;
    } t_b1;

    typedef struct packed {
        tcl_pkg::t_side     side;
        logic signed [51:0] par;
        logic [15:0]        f;
        logic               last;
        logic               short;
    } t_b2;

    typedef struct packed {
        tcl_pkg::t_side     side;
        logic signed [51:0] par;
        logic [31:0]        num;
        logic               short;
    } t_b3;

    // configuration registers
    logic [2:0]         r_mode;
    logic signed [31:0] r_g, r_a, r_b, r_c, r_d, r_e, r_f;
    logic [LW-1:0]      r_len;

    // pipeline registers
    logic               r_v1, r_v2, r_v3, r_vb1, r_vb2, r_vb3;
    t_s1                r_s1, n_s1;
    tcl_pkg::t_side     r_s2, n_s2;
    tcl_pkg::t_side     r_s3, n_s3;
    logic signed [65:0] r_pa, n_pa, r_pc, n_pc;
    t_b1                r_b1, n_b1;
    t_b2                r_b2, n_b2;
    t_b3                r_b3, n_b3;
    logic               r_o_valid;
    logic signed [31:0] r_o_lin, n_o_lin;
    logic               r_o_sat, n_o_sat;

    logic               en;
    logic               accept;
    logic               wr_ok;

    tcl_pkg::t_side     pw_side_in, pw_side_out;
    logic signed [49:0] pw_base;
    logic               pw_valid;
    logic [tcl_pkg::POW_W-1:0] pw_out;

    logic               ram_we;
    logic [AW-1:0]      ram_wa, ram_ra, ram_rb;
    logic [15:0]        ram_qa, ram_qb;

    // Hold everything only when the last stage cannot hand a result over.
    assign en     = !(r_vb3 && !r_b3.side.kind && r_o_valid && !i_ready);
    assign o_ready = en;
    assign accept = i_valid && en;
    assign wr_ok  = (32'(i_entry_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tcl_pkg::MODE_IDENT;
            r_g    <= 32'sd65536;
            r_a    <= 32'sd65536;
            r_b    <= 32'sd0;
            r_c    <= 32'sd0;
            r_d    <= 32'sd0;
            r_e    <= 32'sd0;
            r_f    <= 32'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcl_pkg::CFG_MODE: r_mode <= i_cfg_data[2:0];
                tcl_pkg::CFG_G:    r_g    <= $signed(i_cfg_data);
                tcl_pkg::CFG_A:    r_a    <= $signed(i_cfg_data);
                tcl_pkg::CFG_B:    r_b    <= $signed(i_cfg_data);
                tcl_pkg::CFG_C:    r_c    <= $signed(i_cfg_data);
                tcl_pkg::CFG_D:    r_d    <= $signed(i_cfg_data);
                tcl_pkg::CFG_E:    r_e    <= $signed(i_cfg_data);
                tcl_pkg::CFG_F:    r_f    <= $signed(i_cfg_data);
            endcase
        end
    end

    // Table length follows writes in transfer order; converts take the
    // length seen at their own transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (accept && i_kind && wr_ok) begin
            r_len <= LW'(i_entry_index) + LW'(1);
        end
    end

    // Front stages: capture, magnitude, products.
    always_comb begin
        n_s1.kind = i_kind;
        n_s1.v    = i_sample;
        n_s1.len  = r_len;
        n_s1.widx = i_entry_index;
        n_s1.wval = i_entry_value;

        n_s2      = '0;
        n_s2.kind = r_s1.kind;
        n_s2.neg  = r_s1.v[31];
        n_s2.m    = r_s1.v[31] ? (33'd0 - {1'b1, r_s1.v}) : {1'b0, r_s1.v};
        n_s2.len  = r_s1.len;
        n_s2.widx = r_s1.widx;
        n_s2.wval = r_s1.wval;

        n_s3      = r_s2;
        n_s3.mge  = ($signed({1'b0, r_s2.m}) >= 34'(r_d));
        n_pa      = 66'(r_a) * 66'($signed({1'b0, r_s2.m}));
        n_pc      = 66'(r_c) * 66'($signed({1'b0, r_s2.m}));
    end

    // Round the products; pick the power base.
    always_comb begin
        pw_side_in    = r_s3;
        pw_side_in.cm = 50'((r_pc + 66'sd32768) >>> 16);
        if (r_mode == tcl_pkg::MODE_GAMMA) begin
            pw_base = $signed({17'd0, r_s3.m});
        end else begin
            pw_base = 50'((r_pa + 66'sd32768) >>> 16) + 50'(r_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_pa <= n_pa;
            r_pc <= n_pc;
            r_b1 <= n_b1;
            r_b2 <= n_b2;
            r_b3 <= n_b3;
        end
    end

    tcl_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_base  (pw_base),
        .i_g     (r_g),
        .i_side  (pw_side_in),
        .o_valid (pw_valid),
        .o_pow   (pw_out),
        .o_side  (pw_side_out)
    );

    // Back stage one: table position and parametric combination.
    always_comb begin
        logic [16:0]        xcl;
        logic signed [51:0] pws;
        xcl       = (pw_side_out.m > 33'd65536) ? 17'h10000 : pw_side_out.m[16:0];
        pws       = $signed({3'd0, pw_out});
        n_b1.side = pw_side_out;
        n_b1.pos  = 30'(xcl) * 30'(pw_side_out.len - LW'(1));
        unique case (r_mode)
            tcl_pkg::MODE_GAMMA,
            tcl_pkg::MODE_P1:    n_b1.par = pws;
            tcl_pkg::MODE_P2:    n_b1.par = pws + 52'(r_c);
            tcl_pkg::MODE_P3:    n_b1.par = pw_side_out.mge ? pws : 52'(pw_side_out.cm);
            tcl_pkg::MODE_P4:    n_b1.par = pw_side_out.mge ? (pws + 52'(r_e))
                                                            : (52'(pw_side_out.cm) + 52'(r_f));
            tcl_pkg::MODE_IDENT,
            tcl_pkg::MODE_TABLE,
            tcl_pkg::MODE_SPARE: n_b1.par = $signed({19'd0, pw_side_out.m});
        endcase
    end

    // Back stage two: entry addresses; table writes land here too, so that
    // every convert sees exactly the writes transferred before it.
    always_comb begin
        logic [LW-1:0] idx;
        idx         = r_b1.pos[16 +: LW];
        n_b2.side   = r_b1.side;
        n_b2.par    = r_b1.par;
        n_b2.f      = r_b1.pos[15:0];
        n_b2.last   = ({1'b0, idx} + (LW+1)'(1)) >= {1'b0, r_b1.side.len};
        n_b2.short  = r_b1.side.len < LW'(2);
        ram_ra      = AW'(n_b2.last ? (r_b1.side.len - LW'(1)) : idx);
        ram_rb      = AW'(idx + LW'(1));
        ram_wa      = AW'(r_b1.side.widx);
        ram_we      = en && r_vb1 && r_b1.side.kind
                      && (32'(r_b1.side.widx) < 32'(TABLE_DEPTH));
    end

    tcl_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_wa),
        .i_wdata   (r_b1.side.wval),
        .i_re      (en),
        .i_raddr_a (ram_ra),
        .i_raddr_b (ram_rb),
        .o_rdata_a (ram_qa),
        .o_rdata_b (ram_qb)
    );

    // Back stage three: interpolation numerator.
    always_comb begin
        n_b3.side  = r_b2.side;
        n_b3.par   = r_b2.par;
        n_b3.short = r_b2.short;
        if (r_b2.last) begin
            n_b3.num = {ram_qa, 16'd0};
        end else begin
            n_b3.num = 32'(ram_qa) * 32'(17'h10000 - 17'(r_b2.f))
                     + 32'(ram_qb) * 32'(r_b2.f);
        end
    end

    // Output: divide by 65535 with rounding, select, mirror, saturate.
    always_comb begin
        logic [31:0]        nn;
        logic [15:0]        q0;
        logic [16:0]        rr;
        logic [16:0]        qt;
        logic signed [51:0] rsel;
        logic signed [52:0] rn;
        nn = r_b3.num + 32'd32767;
        q0 = nn[31:16];
        rr = 17'(nn[15:0]) + 17'(q0);
        qt = 17'(q0) + ((rr >= 17'd131070) ? 17'd2 : ((rr >= 17'd65535) ? 17'd1 : 17'd0));
        if (r_mode == tcl_pkg::MODE_TABLE) begin
            rsel = r_b3.short ? $signed({19'd0, r_b3.side.m}) : $signed({35'd0, qt});
        end else begin
            rsel = r_b3.par;
        end
        rn = r_b3.side.neg ? -53'(rsel) : 53'(rsel);
        priority if (rn > 53'sd2147483647) begin
            n_o_lin = 32'sh7fffffff;
            n_o_sat = 1'b1;
        end else if (rn < -53'sd2147483648) begin
            n_o_lin = 32'sh80000000;
            n_o_sat = 1'b1;
        end else begin
            n_o_lin = 32'(rn);
            n_o_sat = 1'b0;
        end
    end

    // Valid bits advance with the data; drop write items at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_vb1     <= 1'b0;
            r_vb2     <= 1'b0;
            r_vb3     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en) begin
                r_v1  <= i_valid;
                r_v2  <= r_v1;
                r_v3  <= r_v2;
                r_vb1 <= pw_valid;
                r_vb2 <= r_vb1;
                r_vb3 <= r_vb2;
            end
            if (en && r_vb3 && !r_b3.side.kind) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vb3 && !r_b3.side.kind) begin
            r_o_lin <= n_o_lin;
            r_o_sat <= n_o_sat;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_linear_value = r_o_lin;
    assign o_saturated    = r_o_sat;

endmodule

`default_nettype wire

/* rtl/tcl_checker.sv */
// Port-level checks of the tone curve linearizer and their bind.
// Depends on tone_curve_linearizer for the bind target.
`default_nettype none

module tcl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_linear_value,
    input wire logic        o_saturated
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_linear_value) && $stable(o_saturated))
        else $error("stalled result changed");

    // drop all results on reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a clipped value sits on a range limit
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> (o_linear_value == 32'h7fffffff
                                    || o_linear_value == 32'h80000000))
        else $error("saturated flag with unclipped value");

    // input may only stall while the output is full and held
    a_ready: assert property (@(posedge i_clk)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind tone_curve_linearizer tcl_checker u_tcl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_linear_value (o_linear_value),
    .o_saturated    (o_saturated)
);

`default_nettype wire

/* dv/tcl_checker.sv */
// Checker for the tone curve linearizer: watches both channels and the
// configuration port, predicts each result and compares. Depends on tcl_pkg.
`timescale 1ns / 100ps

module tcl_scoreboard (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_sample,
    input  logic [11:0]        i_entry_index,
    input  logic [15:0]        i_entry_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_linear_value,
    input  logic               i_saturated,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    localparam longint          ONE_FX  = 64'sd65536;
    localparam longint          POW_MAX = 64'sd1 << 48;
    localparam longint unsigned Q30     = 64'd1 << 30;

    typedef struct {
        logic signed [31:0] value;
        logic               clipped;
    } t_lin_result;

    t_lin_result     linear_q[$];
    logic [15:0]     curve_mem [4096];
    int unsigned     curve_len;
    logic [2:0]      mode;
    longint          g_exp, ca, cb, cc, cd, ce, cf;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] mismatch %s: expected %0d got %0d", $time, what, want, got);
        o_errors++;
    endtask

    // Product of two s15.16 values, rounded half up (>>> floors).
    function automatic longint mul_fx(input longint x, input longint y);
        return (x * y + 32768) >>> 16;
    endfunction

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned res = 0;
        longint unsigned bt  = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= res + bt) begin
                n   = n - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Truncated log2 by repeated squaring of the normalized mantissa.
    function automatic longint log2_fx(input longint x);
        longint unsigned u    = x;
        longint unsigned y;
        longint          frac = 0;
        int              p    = 62;
        while (p > 0 && !u[p])
            p--;
        y = (p >= 30) ? (u >> (p - 30)) : (u << (30 - p));
        for (int k = 0; k < 16; k++) begin
            y    = (y * y) >> 30;
            frac = frac << 1;
            if (y >= 2 * Q30) begin
                y    = y >> 1;
                frac = frac | 1;
            end
        end
        return longint'(p - 16) * ONE_FX + frac;
    endfunction

    // 2^e through a chain of square roots, capped.
    function automatic longint exp2_fx(input longint e);
        longint          ip = e >>> 16;
        longint unsigned fr = e & 64'hFFFF;
        longint unsigned z  = Q30;
        longint unsigned t;
        longint          sh;
        if (ip > 31)
            return POW_MAX;
        for (int j = 0; j < 16; j++) begin
            t = fr[j] ? z * 2 : z;
            z = root64(t << 30);
        end
        sh = 14 - ip;
        if (sh >= 62)
            return 0;
        if (sh > 0) begin
            z = (z + (64'd1 << (sh - 1))) >> sh;
            return longint'(z);
        end
        z = z << (-sh);
        return (longint'(z) > POW_MAX) ? POW_MAX : longint'(z);
    endfunction

    function automatic longint pow_fx(input longint base, input longint g);
        if (base < 0)
            return 0;
        if (base == 0)
            return (g > 0) ? 0 : ((g == 0) ? ONE_FX : POW_MAX);
        return exp2_fx(mul_fx(log2_fx(base), g));
    endfunction

    function automatic longint interp_table(input longint m);
        longint unsigned len = curve_len;
        longint unsigned x, pos, i, f, num;
        if (len < 2)
            return m;
        x   = (m > ONE_FX) ? ONE_FX : m;
        pos = x * (len - 1);
        i   = pos >> 16;
        f   = pos & 64'hFFFF;
        if (i + 1 >= len)
            num = longint'(curve_mem[len - 1]) * ONE_FX;
        else
            num = longint'(curve_mem[i]) * (ONE_FX - f) + longint'(curve_mem[i + 1]) * f;
        return longint'((num + 32767) / 65535);
    endfunction

    function automatic longint curve_mag(input longint m);
        longint base = mul_fx(ca, m) + cb;
        case (mode)
            tcl_pkg::MODE_TABLE: return interp_table(m);
            tcl_pkg::MODE_GAMMA: return pow_fx(m, g_exp);
            tcl_pkg::MODE_P1:    return (base >= 0) ? pow_fx(base, g_exp) : 0;
            tcl_pkg::MODE_P2:    return (base >= 0) ? pow_fx(base, g_exp) + cc : cc;
            tcl_pkg::MODE_P3:    return (m >= cd) ? pow_fx(base, g_exp) : mul_fx(cc, m);
            tcl_pkg::MODE_P4:    return (m >= cd) ? pow_fx(base, g_exp) + ce
                                                  : mul_fx(cc, m) + cf;
            default:             return m;
        endcase
    endfunction

    function automatic t_lin_result linearize(input logic signed [31:0] smp);
        t_lin_result res;
        longint      v = smp;
        longint      r = (v < 0) ? -curve_mag(-v) : curve_mag(v);
        res.clipped = 1'b0;
        if (r > 64'sd2147483647) begin
            r           = 64'sd2147483647;
            res.clipped = 1'b1;
        end else if (r < -64'sd2147483648) begin
            r           = -64'sd2147483648;
            res.clipped = 1'b1;
        end
        res.value = r[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lin_result want;
        if (!i_rst_n) begin
            // table contents survive reset; only the length is cleared
            curve_len = 0;
            mode      = tcl_pkg::MODE_IDENT;
            g_exp     = ONE_FX;
            ca        = ONE_FX;
            cb        = 0;
            cc        = 0;
            cd        = 0;
            ce        = 0;
            cf        = 0;
            linear_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcl_pkg::CFG_MODE: mode  = i_cfg_data[2:0];
                    tcl_pkg::CFG_G:    g_exp = longint'($signed(i_cfg_data));
                    tcl_pkg::CFG_A:    ca    = longint'($signed(i_cfg_data));
                    tcl_pkg::CFG_B:    cb    = longint'($signed(i_cfg_data));
                    tcl_pkg::CFG_C:    cc    = longint'($signed(i_cfg_data));
                    tcl_pkg::CFG_D:    cd    = longint'($signed(i_cfg_data));
                    tcl_pkg::CFG_E:    ce    = longint'($signed(i_cfg_data));
                    default:           cf    = longint'($signed(i_cfg_data));
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_kind) begin
                    curve_mem[i_entry_index] = i_entry_value;
                    curve_len = int'(i_entry_index) + 1;
                end else begin
                    linear_q = {linear_q, linearize(i_sample)};
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (linear_q.size() == 0) begin
                    report_mismatch("unexpected result, value", 0, i_linear_value);
                end else begin
                    want = linear_q.pop_front();
                    if (i_linear_value !== want.value)
                        report_mismatch("linear_value", want.value, i_linear_value);
                    if (i_saturated !== want.clipped)
                        report_mismatch("saturated", want.clipped, i_saturated);
                end
            end
        end
        o_pending = linear_q.size();
    end

endmodule

/* dv/tb_tone_curve_linearizer.sv */
// Testbench top of the tone curve linearizer: clock, reset, stimulus and
// verdict. Depends on tcl_pkg, tone_curve_linearizer and tcl_scoreboard.
`timescale 1ns / 100ps

module tb_tone_curve_linearizer;

    // writes leave no result behind them, so waiting for results does not drain them
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT   = 400000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic               i_kind        = 1'b0;
    logic signed [31:0] i_sample      = '0;
    logic [11:0]        i_entry_index = '0;
    logic [15:0]        i_entry_value = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic signed [31:0] o_linear_value;
    logic               o_saturated;
    logic               i_cfg_we      = 1'b0;
    logic [2:0]         i_cfg_index   = '0;
    logic [31:0]        i_cfg_data    = '0;

    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    bit   gaps_on     = 1'b1;  // sender gaps between transfers
    bit   stalls_on   = 1'b1;  // receiver back-pressure
    int   filled      = 0;     // entries 0..filled-1 of the table hold data

    tone_curve_linearizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_sample       (i_sample),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_linear_value (o_linear_value),
        .o_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    tcl_scoreboard u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_kind         (i_kind),
        .i_sample       (i_sample),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_linear_value (o_linear_value),
        .i_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (error_count),
        .o_pending      (pending_count)
    );

    always #4 i_clk = ~i_clk;

    // Stall the result channel about 11 times in a hundred.
    always @(negedge i_clk)
        i_ready <= stalls_on ? ($urandom_range(0, 99) >= 11) : 1'b1;

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one item at the falling edge, hold it until the transfer, then
    // optionally drop valid for a cycle.
    task automatic push_item(input logic kind, input logic [31:0] smp,
                             input logic [11:0] idx, input logic [15:0] val);
        i_valid       = 1'b1;
        i_kind        = kind;
        i_sample      = smp;
        i_entry_index = idx;
        i_entry_value = val;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 99) < 11) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic convert(input logic [31:0] smp);
        push_item(1'b0, smp, 12'($urandom), 16'($urandom));
    endtask

    // Keep the written region a prefix so no unwritten entry is ever read.
    task automatic load_entry(input int idx, input logic [15:0] val);
        if (idx == filled)
            filled++;
        push_item(1'b1, $urandom, 12'(idx), val);
    endtask

    task automatic wait_results;
        i_valid = 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    // Drain, let trailing writes leave the pipeline, then reprogram.
    task automatic set_curve(input logic [2:0] mode, input logic [31:0] g,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d,
                             input logic [31:0] e, input logic [31:0] f);
        logic [31:0] vals [8];
        vals = '{32'(mode), g, a, b, c, d, e, f};
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        for (int r = 0; r < 8; r++) begin
            i_cfg_we    = 1'b1;
            i_cfg_index = 3'(r);
            i_cfg_data  = vals[r];
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 32'($signed($urandom_range(0, 262144)) - 131072);
            5, 6:          return $urandom;
            7: begin
                case ($urandom_range(0, 7))
                    0:       return 32'h0;
                    1:       return 32'h1;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h7FFF_FFFF;
                    4:       return 32'h8000_0000;
                    5:       return 32'h0001_0000;
                    6:       return 32'hFFFF_0000;
                    default: return 32'h0000_FFFF;
                endcase
            end
            default:       return 32'($signed($urandom_range(0, 8388608)) - 4194304);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0, 1:    return 32'($signed($urandom_range(0, 131072)) - 65536);
            2:       return 32'($signed($urandom_range(0, 524288)) - 262144);
            3:       return 32'($urandom_range(32768, 98304));
            4:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_gamma();
        case ($urandom_range(0, 7))
            0:       return 32'($signed($urandom_range(0, 131072)) - 131072);
            1:       return $urandom;
            default: return 32'($urandom_range(13107, 262144));
        endcase
    endfunction

    task automatic run_mix(input int n, input int write_pct, input bit pause_mid);
        int idx;
        for (int k = 0; k < n; k++) begin
            if (pause_mid && k == n / 2)
                wait_results();
            if ($urandom_range(0, 99) < write_pct) begin
                idx = $urandom_range(0, 1) ? $urandom_range(0, 15)
                                           : $urandom_range(0, filled < 4096 ? filled : 4095);
                load_entry(idx, 16'($urandom));
            end else begin
                convert(rand_sample());
            end
        end
    endtask

    initial begin
        logic [2:0] mode;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Identity at reset values; field extremes.
        convert(32'h0);
        convert(32'h1);
        convert(32'hFFFF_FFFF);
        convert(32'h7FFF_FFFF);
        convert(32'h8000_0000);
        convert(32'h0001_0000);
        convert(32'hFFFF_0000);

        // Table with no entries and with one entry acts as identity.
        set_curve(tcl_pkg::MODE_TABLE, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0, 0);
        convert(32'h8000);
        load_entry(0, 16'h0000);
        convert(32'h8000);
        load_entry(1, 16'hFFFF);
        convert(32'h0);
        convert(32'h8000);
        convert(32'h1_0000);
        convert(32'h3_0D40);      // past the last entry
        convert(32'hFFFF_8000);
        convert(32'h8000_0000);

        // Spare mode code falls back to identity.
        set_curve(tcl_pkg::MODE_SPARE, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0, 0);
        convert(32'hFFFF_FFFB);

        // Zero base with positive, zero and negative exponent; huge power.
        set_curve(tcl_pkg::MODE_GAMMA, 32'h2_3333, 32'h1_0000, 0, 0, 0, 0, 0);
        convert(32'h0);
        convert(32'h0000_8000);
        set_curve(tcl_pkg::MODE_GAMMA, 32'h0, 32'h1_0000, 0, 0, 0, 0, 0);
        convert(32'h0);
        set_curve(tcl_pkg::MODE_GAMMA, 32'hFFFF_0000, 32'h1_0000, 0, 0, 0, 0, 0);
        convert(32'h0);
        set_curve(tcl_pkg::MODE_GAMMA, 32'h7FFF_FFFF, 32'h1_0000, 0, 0, 0, 0, 0);
        convert(32'h7FFF_FFFF);
        convert(32'h8000_0001);

        // Negative base below the threshold of type 1.
        set_curve(tcl_pkg::MODE_P1, 32'h2_0000, 32'h1_0000, 32'hFFFF_8000, 0, 0, 0, 0);
        convert(32'h0000_03E8);
        convert(32'h0000_C000);

        // Fill a prefix of the table; later writes stay within it or extend it.
        set_curve(tcl_pkg::MODE_TABLE, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0, 0);
        for (int k = 0; k < 64; k++)
            load_entry(k, (k == 2) ? 16'hFFFF : (k == 3) ? 16'h0000 : 16'($urandom));
        convert(32'h1_0000);
        convert(32'h0000_8000);

        // Random phases over every mode with random and extreme settings.
        for (int ph = 0; ph < 14; ph++) begin
            mode      = 3'(ph % 8);
            gaps_on   = (ph != 3);
            stalls_on = (ph != 3);
            if (ph == 5)
                set_curve(tcl_pkg::MODE_P4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            else if (ph == 6)
                set_curve(tcl_pkg::MODE_P4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            else if (ph == 12)
                set_curve(tcl_pkg::MODE_P3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
            else
                set_curve(mode, rand_gamma(), rand_coef(), rand_coef(), rand_coef(),
                          rand_coef(), rand_coef(), rand_coef());
            run_mix(105, (mode == tcl_pkg::MODE_TABLE) ? 15 : 5, ph == 2);
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tcl_pkg.sv
rtl/tcl_ram.sv
rtl/tcl_pow.sv
rtl/tone_curve_linearizer.sv
rtl/tcl_checker.sv
dv/tcl_checker.sv
dv/tb_tone_curve_linearizer.sv
